[hdl/teq_pkg.sv]
// Package: shared constants and types for the timer event queue.
package teq_pkg;

    localparam int CAPACITY = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int FIFO_DEPTH = 2;

    localparam logic [1:0] FUNC_SET    = 2'd0;
    localparam logic [1:0] FUNC_CANCEL = 2'd1;
    localparam logic [1:0] FUNC_PEEK   = 2'd2;
    localparam logic [1:0] FUNC_POP    = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    localparam logic [31:0] NO_TIME = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] expiry_time;
        logic [15:0] node_id;
        logic [31:0] cookie_tag;
    } cmd_t;

    typedef struct packed {
        logic [31:0] t;
        logic [15:0] node;
        logic [31:0] cookie;
    } entry_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] head_time;
        logic [15:0] head_node;
        logic [31:0] head_cookie;
        logic [5:0]  pending_count;
    } result_t;

endpackage

[hdl/teq_front.sv]
// Front end: accept items and hold them in a short command queue.
module teq_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  teq_pkg::cmd_t in_cmd,
    output logic          cmd_valid,
    input  logic          cmd_ready,
    output teq_pkg::cmd_t cmd
);

    teq_pkg::cmd_t mem_reg [teq_pkg::FIFO_DEPTH];
    logic          wp_reg;
    logic          rp_reg;
    logic [1:0]    cnt_reg;
    logic          push;
    logic          pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = mem_reg[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= in_cmd;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3)
        else $error("command queue count out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2) |-> !in_ready)
        else $error("command queue accepts while full");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0) |=> !(pop && $past(!push)))
        else $error("command queue pops while empty");

endmodule

[hdl/teq_back.sv]
// Back end: sorted shift-register cell array that executes commands.
module teq_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  teq_pkg::cmd_t    cmd,
    output logic             res_valid,
    input  logic             res_ready,
    output teq_pkg::result_t res
);

    localparam int N = teq_pkg::CAPACITY;
    localparam int W = teq_pkg::CNT_W;

    typedef enum logic [0:0] { S_EVAL, S_EXEC } state_t;

    state_t            state_reg;
    teq_pkg::entry_t   cell_reg [N];
    logic [W-1:0]      occ_reg;
    logic [N-1:0]      le_reg;
    logic [N-1:0]      hit_reg;
    teq_pkg::cmd_t     cur_reg;
    logic              res_valid_reg;
    teq_pkg::result_t  res_reg;

    logic [N-1:0] valid_v;
    logic [N-1:0] le_next;
    logic [N-1:0] hit_next;
    logic [N-1:0] first_hit;
    logic [N-1:0] del_mask;
    logic [N-1:0] ins_after;
    logic         found;
    logic         full;
    logic [5:0]   occ6_next;
    logic [W-1:0] occ_next;
    teq_pkg::result_t res_next;
    logic         do_ins;
    logic         do_del;

    // the result register frees up at the same edge that it is taken
    assign cmd_ready = (state_reg == S_EVAL) && (!res_valid_reg || res_ready);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            valid_v[i]  = (W'(i) < occ_reg);
            le_next[i]  = valid_v[i] && (cell_reg[i].t <= cmd.expiry_time);
            hit_next[i] = valid_v[i] && (cell_reg[i].t == cmd.expiry_time)
                          && (cell_reg[i].node == cmd.node_id)
                          && (cell_reg[i].cookie == cmd.cookie_tag);
        end
    end

    // first match by lowest-set-bit isolation; cells at and above it shift down
    assign first_hit = hit_reg & (~hit_reg + N'(1));
    assign found     = |hit_reg;
    assign full      = (occ_reg == W'(N));
    assign del_mask  = ~(first_hit - N'(1));
    assign ins_after = ~le_reg;

    always_comb
    begin
        do_ins   = 1'b0;
        do_del   = 1'b0;
        occ_next = occ_reg;
        res_next = '0;
        case (cur_reg.func)
            teq_pkg::FUNC_SET:
            begin
                if (full)
                begin
                    res_next.status = teq_pkg::ST_FULL;
                end
                else
                begin
                    do_ins   = 1'b1;
                    occ_next = occ_reg + W'(1);
                end
            end
            teq_pkg::FUNC_CANCEL:
            begin
                if (found)
                begin
                    do_del   = 1'b1;
                    occ_next = occ_reg - W'(1);
                end
                else
                begin
                    res_next.status = teq_pkg::ST_NOT_FOUND;
                end
            end
            teq_pkg::FUNC_PEEK:
            begin
                if (occ_reg == '0)
                begin
                    res_next.status    = teq_pkg::ST_EMPTY;
                    res_next.head_time = teq_pkg::NO_TIME;
                end
                else
                begin
                    res_next.head_time = cell_reg[0].t;
                end
            end
            default:
            begin
                if (occ_reg == '0)
                begin
                    res_next.status = teq_pkg::ST_EMPTY;
                end
                else
                begin
                    do_del               = 1'b1;
                    occ_next             = occ_reg - W'(1);
                    res_next.head_time   = cell_reg[0].t;
                    res_next.head_node   = cell_reg[0].node;
                    res_next.head_cookie = cell_reg[0].cookie;
                end
            end
        endcase
        occ6_next              = 6'(occ_next);
        res_next.pending_count = occ6_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_EVAL;
            occ_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (res_valid_reg && res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_EVAL:
                begin
                    if (cmd_valid && cmd_ready)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    occ_reg       <= occ_next;
                    res_valid_reg <= 1'b1;
                    state_reg     <= S_EVAL;
                end
                default:
                begin
                    state_reg <= S_EVAL;
                end
            endcase
        end
    end

    // payload: compare vectors, command latch, cell shifts, result
    always_ff @(posedge clk)
    begin
        if (state_reg == S_EVAL && cmd_valid && cmd_ready)
        begin
            cur_reg <= cmd;
            le_reg  <= le_next;
            hit_reg <= (cmd.func == teq_pkg::FUNC_POP) ? N'(1) : hit_next;
        end
        if (state_reg == S_EXEC)
        begin
            res_reg <= res_next;
            for (int i = 0; i < N; i++)
            begin
                if (do_ins && ins_after[i])
                begin
                    if (i == 0 || le_reg[(i == 0) ? 0 : i - 1])
                    begin
                        cell_reg[i] <= {cur_reg.expiry_time, cur_reg.node_id,
                                        cur_reg.cookie_tag};
                    end
                    else
                    begin
                        cell_reg[i] <= cell_reg[(i == 0) ? 0 : i - 1];
                    end
                end
                else if (do_del && del_mask[i] && i < N - 1)
                begin
                    cell_reg[i] <= cell_reg[(i < N - 1) ? i + 1 : i];
                end
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) occ_reg <= W'(N))
        else $error("occupancy above capacity");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) |=> res_valid_reg)
        else $error("executed command gave no result");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) |-> $onehot0(first_hit))
        else $error("more than one cancel target");
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_ready) |=> $stable(occ_reg))
        else $error("queue changed while result stalled");

endmodule

[hdl/timer_event_queue_top.sv]
// Top level: timer event queue with stream command and result channels.
// Flow: an item accepted into the two-entry command queue is compared against
// the cell array when the back end takes it (compare vectors registered), and
// the cells shift in the execute state, where its result is registered.
// The back end takes no new item until the last is done (compare, then shift) and its result is taken.
// Reset: rst_n low empties the queue and command buffer; cell payload is kept.
module timer_event_queue_top
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [87:0]  s_tdata,  // expiry_time[31:0], node_id[47:32], cookie_tag[79:48], pad
    input  logic [1:0]   s_tuser,  // func
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [87:0]  m_tdata,  // head_time, head_node, head_cookie, pending_count, pad
    output logic [1:0]   m_tuser   // status
);

    teq_pkg::cmd_t    in_cmd;
    teq_pkg::cmd_t    cmd;
    teq_pkg::result_t res;
    logic             cmd_valid;
    logic             cmd_ready;
    logic             unused_pad;

    assign in_cmd.func        = s_tuser;
    assign in_cmd.expiry_time = s_tdata[31:0];
    assign in_cmd.node_id     = s_tdata[47:32];
    assign in_cmd.cookie_tag  = s_tdata[79:48];
    assign unused_pad         = ^s_tdata[87:80];

    teq_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (in_cmd),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    teq_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    // pack result fields lowest first
    assign m_tuser = res.status;
    assign m_tdata = {2'b00, res.pending_count, res.head_cookie, res.head_node,
                      res.head_time};

endmodule

[dv/teq_checker.sv]
// Checker: predicts timer queue results and compares them with the output channel.
`timescale 1ns / 100ps
module teq_checker
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [87:0]  s_tdata,
    input  logic [1:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [87:0]  m_tdata,
    input  logic [1:0]   m_tuser,
    output int           errors,
    output int           outstanding,
    output int           results_seen
);

    teq_pkg::entry_t    slots[$];
    teq_pkg::result_t   expected_q[$];

    task automatic report(input string what, input logic [31:0] got,
                          input logic [31:0] want);
        $display("MISMATCH %s at %0t: got %0h expected %0h", what, $realtime, got, want);
        errors++;
    endtask

    // Apply one command to the shadow queue and return what the block should answer.
    function automatic teq_pkg::result_t apply_cmd(input logic [1:0] fn,
                                                   input teq_pkg::entry_t e);
        teq_pkg::result_t r;
        int pos;
        r = '0;
        r.status = teq_pkg::ST_OK;
        case (fn)
            teq_pkg::FUNC_SET:
                if (slots.size() >= teq_pkg::CAPACITY)
                    r.status = teq_pkg::ST_FULL;
                else
                begin
                    pos = 0;
                    while (pos < slots.size() && slots[pos].t <= e.t)
                        pos++;
                    slots.insert(pos, e);
                end
            teq_pkg::FUNC_CANCEL:
            begin
                r.status = teq_pkg::ST_NOT_FOUND;
                for (int i = 0; i < slots.size(); i++)
                    if (slots[i] == e)
                    begin
                        slots.delete(i);
                        r.status = teq_pkg::ST_OK;
                        break;
                    end
            end
            teq_pkg::FUNC_PEEK:
                if (slots.size() == 0)
                begin
                    r.status    = teq_pkg::ST_EMPTY;
                    r.head_time = teq_pkg::NO_TIME;
                end
                else
                    r.head_time = slots[0].t;
            default:
                if (slots.size() == 0)
                    r.status = teq_pkg::ST_EMPTY;
                else
                begin
                    r.head_time   = slots[0].t;
                    r.head_node   = slots[0].node;
                    r.head_cookie = slots[0].cookie;
                    slots.delete(0);
                end
        endcase
        r.pending_count = 6'(slots.size());
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        teq_pkg::entry_t  e;
        teq_pkg::result_t got;
        teq_pkg::result_t want;
        if (!rst_n)
        begin
            slots.delete();
            expected_q.delete();
            errors       = 0;
            results_seen = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                e.t      = s_tdata[31:0];
                e.node   = s_tdata[47:32];
                e.cookie = s_tdata[79:48];
                expected_q.push_back(apply_cmd(s_tuser, e));
            end
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                got.status        = m_tuser;
                got.head_time     = m_tdata[31:0];
                got.head_node     = m_tdata[47:32];
                got.head_cookie   = m_tdata[79:48];
                got.pending_count = m_tdata[85:80];
                if (expected_q.size() == 0)
                    report("unexpected result", 32'd0, 32'd0);
                else
                begin
                    want = expected_q.pop_front();
                    if (got.status != want.status)
                        report("status", 32'(got.status), 32'(want.status));
                    if (got.head_time != want.head_time)
                        report("head_time", got.head_time, want.head_time);
                    if (got.head_node != want.head_node)
                        report("head_node", 32'(got.head_node), 32'(want.head_node));
                    if (got.head_cookie != want.head_cookie)
                        report("head_cookie", got.head_cookie, want.head_cookie);
                    if (got.pending_count != want.pending_count)
                        report("pending_count", 32'(got.pending_count),
                               32'(want.pending_count));
                end
            end
        end
        outstanding = expected_q.size();
    end

endmodule

[dv/tb.sv]
// Testbench top: drives timer queue commands, stalls the result side, reports the verdict.
`timescale 1ns / 100ps
module tb;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [87:0]  s_tdata = '0;
    logic [1:0]   s_tuser = teq_pkg::FUNC_SET;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [87:0]  m_tdata;
    logic [1:0]   m_tuser;
    int           errors;
    int           outstanding;
    int           results_seen;
    int           n_sent = 0;
    bit           long_hold = 1'b0;   // set by stimulus to request the long receiver stall
    bit           hold_done = 1'b0;   // set by the receiver once the long stall is over
    bit           gaps_on = 1'b1;     // cleared for stretches of back-to-back traffic

    // Recently set timers, kept so cancels can hit real entries.
    teq_pkg::entry_t recent[$];

    always #10 clk = ~clk;

    timer_event_queue_top i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    teq_checker i_checker
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .errors       (errors),
        .outstanding  (outstanding),
        .results_seen (results_seen)
    );

    // After a random gap with valid low, offer one item and hold it until accepted.
    task automatic send_cmd(input logic [1:0] fn, input teq_pkg::entry_t e);
        int gap;
        gap = gaps_on ? $urandom_range(0, 3) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= {8'h00, e.cookie, e.node, e.t};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        n_sent++;
        if (fn == teq_pkg::FUNC_SET)
        begin
            recent.push_back(e);
            if (recent.size() > 48)
                void'(recent.pop_front());
        end
    endtask

    function automatic teq_pkg::entry_t rand_entry(input bit narrow);
        teq_pkg::entry_t e;
        // Narrow times force ties so first-in order among equals gets exercised.
        e.t      = narrow ? $urandom_range(0, 7) : $urandom();
        e.node   = 16'($urandom());
        e.cookie = $urandom();
        return e;
    endfunction

    // Receiver: random stalls, one long hold-off on request.
    initial
    begin
        int wait_cycles;
        @(posedge clk);
        forever
        begin
            if (long_hold && !hold_done)
            begin
                m_tready <= 1'b0;
                repeat (60) @(posedge clk);
                hold_done = 1'b1;
            end
            wait_cycles = gaps_on ? $urandom_range(0, 3) : 0;
            if (wait_cycles > 0)
            begin
                m_tready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
            begin
                if (long_hold && !hold_done)
                    break;
                @(posedge clk);
            end
        end
    end

    initial
    begin
        #50ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        teq_pkg::entry_t e;
        teq_pkg::entry_t ones;
        int     r;
        int     settle;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty peek and pop, extremes, ties, miss.
        ones = '{t: 32'hFFFF_FFFF, node: 16'hFFFF, cookie: 32'hFFFF_FFFF};
        send_cmd(teq_pkg::FUNC_PEEK, '0);
        send_cmd(teq_pkg::FUNC_POP, '0);
        send_cmd(teq_pkg::FUNC_CANCEL, ones);
        send_cmd(teq_pkg::FUNC_SET, ones);
        send_cmd(teq_pkg::FUNC_SET, '0);
        send_cmd(teq_pkg::FUNC_SET, '{t: 32'd5, node: 16'd1, cookie: 32'd1});
        send_cmd(teq_pkg::FUNC_SET, '{t: 32'd5, node: 16'd2, cookie: 32'd2});
        send_cmd(teq_pkg::FUNC_PEEK, ones);
        send_cmd(teq_pkg::FUNC_CANCEL, '{t: 32'd5, node: 16'd2, cookie: 32'd3});
        send_cmd(teq_pkg::FUNC_CANCEL, '{t: 32'd5, node: 16'd2, cookie: 32'd2});
        send_cmd(teq_pkg::FUNC_POP, '0);
        send_cmd(teq_pkg::FUNC_POP, '0);
        send_cmd(teq_pkg::FUNC_CANCEL, ones);
        send_cmd(teq_pkg::FUNC_POP, '0);
        send_cmd(teq_pkg::FUNC_POP, '0);

        // Fill past capacity while the receiver holds off, so the input backs up.
        long_hold = 1'b1;
        gaps_on   = 1'b0;
        for (int i = 0; i < teq_pkg::CAPACITY + 3; i++)
            send_cmd(teq_pkg::FUNC_SET, rand_entry(i[0]));
        gaps_on = 1'b1;
        for (int i = 0; i < teq_pkg::CAPACITY + 2; i++)
            send_cmd(teq_pkg::FUNC_POP, '0);

        // Random phase: bias the mix with occupancy swings; cancels mostly hit.
        while (n_sent < 1750)
        begin
            gaps_on = ($urandom_range(0, 7) != 0);
            r = $urandom_range(0, 99);
            if ((n_sent / 200) % 2 == 0 ? r < 55 : r < 30)
                send_cmd(teq_pkg::FUNC_SET, rand_entry(1'($urandom_range(0, 1))));
            else if (r < 70)
            begin
                if (recent.size() > 0 && $urandom_range(0, 3) != 0)
                    e = recent[$urandom_range(0, recent.size() - 1)];
                else
                    e = rand_entry(1'b1);
                send_cmd(teq_pkg::FUNC_CANCEL, e);
            end
            else if (r < 82)
                send_cmd(teq_pkg::FUNC_PEEK, rand_entry(1'b0));
            else
                send_cmd(teq_pkg::FUNC_POP, '0);
        end
        s_tvalid <= 1'b0;

        settle = 0;
        while (outstanding != 0 && settle < 2000)
        begin
            @(posedge clk);
            settle++;
        end
        repeat (10) @(posedge clk);

        $display("Ran %0d commands (set, cancel, peek, pop) with ties, full and empty queue",
                 n_sent);
        $display("and a long result stall; %0d results checked", results_seen);
        if (errors == 0 && outstanding == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
